FILE: src/volatility_quote_ladder_top_macros.svh
// Assertion macros used by the checker file.
`ifndef VOLATILITY_QUOTE_LADDER_TOP_MACROS_SVH
`define VOLATILITY_QUOTE_LADDER_TOP_MACROS_SVH

// Checked outside reset.
`define VQL_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// Checked during reset as well.
`define VQL_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) else $error("reset assertion failed");

`endif

FILE: src/vql_pkg.sv
// Shared types and constants of the volatility quote ladder.
package vql_pkg;

  localparam int WINDOW     = 32;
  localparam int AW         = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int MAX_LEVELS = 8;
  localparam int LVL_W      = 4;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int RET_W      = 29;
  localparam int SUM_W      = 34;

  localparam logic [28:0] ONE_Q24   = 29'h100_0000;
  localparam logic [27:0] RET_CAP   = 28'h800_0000;
  localparam logic [22:0] DEPTH_MAX = 23'h7f_ffff;

  typedef enum logic [2:0] {
    REG_LEVELS      = 3'd0,
    REG_BASE_DEPTH  = 3'd1,
    REG_BASE_SPREAD = 3'd2,
    REG_VOL_MULT    = 3'd3,
    REG_MAX_HALF    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]  levels;
    logic [19:0] unit_depth;
    logic [24:0] base_spread;
    logic [15:0] vol_mult;
    logic [24:0] max_half;
  } cfg_t;

  typedef struct packed {
    logic [31:0] price;
    logic        upd;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        side;
    logic [3:0]  level;
    logic [31:0] price;
    logic [22:0] depth;
    logic        last;
  } quote_t;

endpackage

FILE: src/vql_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vql_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/vql_front.sv
// Input stage: registers each transfer and drops zero prices.
module vql_front import vql_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  output logic  push,
  output item_t push_item,
  input  logic  full
);

  logic  vld;
  item_t item;
  logic  drain;

  assign drain     = vld && ((item.price == 32'd0) || !full);
  assign push      = vld && (item.price != 32'd0) && !full;
  assign push_item = item;
  assign s_ready   = !vld || drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_valid && s_ready) begin
      vld <= 1'b1;
    end else if (drain) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

FILE: src/vql_fifo.sv
// Short queue between the front and the back.
module vql_fifo import vql_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t item
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  assign full  = (count == QDEPTH[QAW:0]);
  assign valid = (count != '0);
  assign item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

FILE: src/vql_div.sv
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
module vql_div import vql_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] den;
  logic [63:0] q;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh   = {rem, q[63]};
  assign ge       = (rem_sh >= {1'b0, den});
  assign rsp.quo  = q;
  assign rsp.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd63);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        den  <= req.den;
        q    <= req.num;
      end else if (busy) begin
        if (ge) begin
          rem <= 32'(rem_sh - {1'b0, den});
        end else begin
          rem <= rem_sh[31:0];
        end
        q   <= {q[62:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: src/vql_back.sv
// Back end: window update, volatility sequencer and quote ladder.
module vql_back import vql_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   q_valid,
  input  item_t  q_item,
  output logic   q_pop,
  output logic   m_valid,
  input  logic   m_ready,
  output quote_t m_quote
);

  typedef enum logic [4:0] {
    S_IDLE, S_VOL, S_P1_RDP, S_P1_RDC, S_P1_CALC, S_P1_DIV, S_P1_STORE,
    S_MEAN, S_MEAN_WAIT, S_P2_RD, S_P2_SQ, S_P2_ACC, S_VAR, S_VAR_WAIT,
    S_SQRT, S_HALF_MUL, S_HALF, S_LV_MUL_B, S_LV_EMIT_B, S_LV_MUL_A, S_LV_EMIT_A
  } state_t;

  state_t state;

  logic [AW-1:0]    head;
  logic [CNT_W-1:0] count;
  logic [AW-1:0]    oldest;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] k;
  logic [31:0]      price;
  logic [31:0]      prev;
  logic             neg;
  logic [27:0]      r_mag;
  logic signed [SUM_W-1:0] sum;
  logic signed [RET_W-1:0] mean;
  logic [57:0]      sq_prod;
  logic [63:0]      sq;
  logic [63:0]      sx;
  logic [63:0]      res;
  logic [63:0]      sbit;
  logic [4:0]       scnt;
  logic [47:0]      hprod;
  logic [24:0]      half;
  logic [3:0]       lv;
  logic [3:0]       lvl;
  logic [28:0]      offs;
  logic [23:0]      depth_acc;
  logic [60:0]      mprod;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // window RAM and return RAM
  logic             win_we;
  logic [AW-1:0]    win_raddr;
  logic [31:0]      win_rdata;
  logic             ret_we;
  logic [RET_W-1:0] ret_wdata;
  logic [RET_W-1:0] ret_rdata;

  vql_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_win (
    .clk(clk), .we(win_we), .waddr(head), .wdata(q_item.price),
    .raddr(win_raddr), .rdata(win_rdata)
  );

  vql_ram #(.WIDTH(RET_W), .DEPTH(WINDOW)) u_ret (
    .clk(clk), .we(ret_we), .waddr(k[AW-1:0]), .wdata(ret_wdata),
    .raddr(k[AW-1:0]), .rdata(ret_rdata)
  );

  vql_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  logic signed [RET_W-1:0] r_val;
  logic [31:0]      mag;
  logic             cur_lt;
  logic signed [29:0] d;
  logic [28:0]      dmag;
  logic [63:0]      trial;
  logic [40:0]      hsum;
  logic [31:0]      bid;
  logic [36:0]      ask;
  logic [28:0]      mop;
  logic             out_free;
  logic [22:0]      depth_sat;
  logic [SUM_W-1:0] sum_mag;
  logic             ret_big;
  logic             div_go;
  logic             bid_ok;
  logic             emit_now;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign win_we    = q_pop && q_item.upd;
  assign win_raddr = oldest + k[AW-1:0] - AW'(state == S_P1_RDP);
  assign ret_we    = (state == S_P1_STORE);
  assign r_val     = neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
  assign ret_wdata = r_val;
  assign cur_lt    = win_rdata < prev;
  assign mag       = cur_lt ? (prev - win_rdata) : (win_rdata - prev);
  assign d         = 30'($signed(ret_rdata)) - 30'(mean);
  assign dmag      = d[29] ? 29'(-d) : d[28:0];
  assign trial     = res + sbit;
  assign hsum      = 41'(cfg.base_spread) + 41'(hprod[47:8]);
  assign bid       = mprod[55:24];
  assign ask       = mprod[60:24];
  assign mop       = (state == S_LV_MUL_B) ? (ONE_Q24 - offs) : (ONE_Q24 + offs);
  assign out_free  = !m_valid || m_ready;
  assign depth_sat = (depth_acc > {1'b0, DEPTH_MAX}) ? DEPTH_MAX : depth_acc[22:0];
  assign sum_mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  // return of 8.0 or more is capped without a divide
  assign ret_big   = ({3'b000, mag} >= {prev, 3'b000});
  assign div_go    = ((state == S_P1_CALC) && (prev != 32'd0) && !ret_big) ||
                     (state == S_MEAN) || (state == S_VAR);
  assign bid_ok    = (offs < ONE_Q24) && (bid != 32'd0);
  assign emit_now  = out_free && (((state == S_LV_EMIT_B) && bid_ok) ||
                                  (state == S_LV_EMIT_A));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      count         <= '0;
      m_valid       <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= div_go;
      if (emit_now) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            price <= q_item.price;
            if (q_item.upd) begin
              head <= head + 1'b1;
              if (count != CNT_W'(WINDOW)) begin
                count <= count + 1'b1;
              end
            end
            state <= S_VOL;
          end
        end
        S_VOL: begin
          if (count < CNT_W'(2)) begin
            state <= S_HALF_MUL;
          end else begin
            oldest <= head - count[AW-1:0];
            n      <= count - 1'b1;
            k      <= CNT_W'(1);
            sum    <= '0;
            state  <= S_P1_RDP;
          end
        end
        S_P1_RDP: state <= S_P1_RDC;
        S_P1_RDC: begin
          prev  <= win_rdata;
          state <= S_P1_CALC;
        end
        S_P1_CALC: begin
          neg <= cur_lt;
          if (prev == 32'd0) begin
            r_mag <= '0;
            state <= S_P1_STORE;
          end else if (ret_big) begin
            r_mag <= RET_CAP;
            state <= S_P1_STORE;
          end else begin
            div_req.num <= {8'd0, mag, 24'd0};
            div_req.den <= prev;
            state       <= S_P1_DIV;
          end
        end
        S_P1_DIV: begin
          if (div_rsp.done) begin
            r_mag <= div_rsp.quo[27:0];
            state <= S_P1_STORE;
          end
        end
        S_P1_STORE: begin
          sum <= sum + SUM_W'(r_val);
          if (k == n) begin
            state <= S_MEAN;
          end else begin
            k     <= k + 1'b1;
            state <= S_P1_RDP;
          end
        end
        S_MEAN: begin
          div_req.num <= 64'(sum_mag);
          div_req.den <= 32'(n);
          state       <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_rsp.done) begin
            mean  <= sum[SUM_W-1] ? -$signed({1'b0, div_rsp.quo[27:0]})
                                  : $signed({1'b0, div_rsp.quo[27:0]});
            k     <= CNT_W'(1);
            sq    <= '0;
            state <= S_P2_RD;
          end
        end
        S_P2_RD: state <= S_P2_SQ;
        S_P2_SQ: begin
          sq_prod <= dmag * dmag;
          state   <= S_P2_ACC;
        end
        S_P2_ACC: begin
          sq <= sq + 64'(sq_prod);
          if (k == n) begin
            state <= S_VAR;
          end else begin
            k     <= k + 1'b1;
            state <= S_P2_RD;
          end
        end
        S_VAR: begin
          div_req.num <= sq;
          div_req.den <= 32'(n);
          state       <= S_VAR_WAIT;
        end
        S_VAR_WAIT: begin
          if (div_rsp.done) begin
            sx    <= div_rsp.quo;
            res   <= '0;
            sbit  <= 64'h4000_0000_0000_0000;
            scnt  <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sx >= trial) begin
            sx  <= sx - trial;
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          scnt <= scnt + 1'b1;
          if (scnt == 5'd31) begin
            state <= S_HALF_MUL;
          end
        end
        S_HALF_MUL: begin
          if (count >= CNT_W'(2)) begin
            hprod <= res[31:0] * cfg.vol_mult;
          end else begin
            hprod <= '0;
          end
          state <= S_HALF;
        end
        S_HALF: begin
          half      <= (hsum > 41'(cfg.max_half)) ? cfg.max_half : hsum[24:0];
          offs      <= (hsum > 41'(cfg.max_half)) ? 29'(cfg.max_half) : 29'(hsum[24:0]);
          lv        <= (cfg.levels > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : cfg.levels;
          lvl       <= 4'd1;
          depth_acc <= 24'(cfg.unit_depth);
          if (cfg.levels == 4'd0) begin
            state <= S_IDLE;
          end else begin
            state <= S_LV_MUL_B;
          end
        end
        S_LV_MUL_B: begin
          mprod <= price * mop;
          state <= S_LV_EMIT_B;
        end
        S_LV_EMIT_B: begin
          if (bid_ok) begin
            if (out_free) begin
              m_quote.side  <= 1'b0;
              m_quote.level <= lvl;
              m_quote.price <= bid;
              m_quote.depth <= depth_sat;
              m_quote.last  <= 1'b0;
              state         <= S_LV_MUL_A;
            end
          end else begin
            state <= S_LV_MUL_A;
          end
        end
        S_LV_MUL_A: begin
          mprod <= price * mop;
          state <= S_LV_EMIT_A;
        end
        S_LV_EMIT_A: begin
          if (out_free) begin
            m_quote.side  <= 1'b1;
            m_quote.level <= lvl;
            m_quote.price <= (ask[36:32] != 5'd0) ? 32'hffff_ffff : ask[31:0];
            m_quote.depth <= depth_sat;
            m_quote.last  <= (lvl == lv);
            if (lvl == lv) begin
              state <= S_IDLE;
            end else begin
              lvl       <= lvl + 1'b1;
              offs      <= offs + 29'(half);
              depth_acc <= depth_acc + 24'(cfg.unit_depth);
              state     <= S_LV_MUL_B;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/volatility_quote_ladder_top.sv
// Each item passes the front and the queue; each return in the window then takes
// one divide (none if capped or the previous price is zero), followed by a second pass,
// the mean, variance and square root, and the quote steps per level. One item at a time;
// the single bit-per-cycle divider is shared by all divisions.
// Zero prices are dropped at the input and produce no transfer.
// rst is synchronous: clears control state, window count and head; config resets.
module volatility_quote_ladder_top import vql_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] price
  input  logic        s_tuser,   // [0] record flag
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [3:0] level, [35:4] quote_price, [58:36] depth
  output logic        m_tuser,   // [0] side
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  cfg_t   cfg;
  item_t  s_item;
  item_t  push_item;
  item_t  q_item;
  logic   push;
  logic   full;
  logic   q_pop;
  logic   q_valid;
  quote_t quote;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.levels      <= 4'd3;
      cfg.unit_depth  <= 20'd100;
      cfg.base_spread <= 25'd16777;
      cfg.vol_mult    <= 16'd256;
      cfg.max_half    <= 25'd838861;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_LEVELS:      cfg.levels      <= cfg_data[3:0];
        REG_BASE_DEPTH:  cfg.unit_depth  <= cfg_data[19:0];
        REG_BASE_SPREAD: cfg.base_spread <= cfg_data;
        REG_VOL_MULT:    cfg.vol_mult    <= cfg_data[15:0];
        REG_MAX_HALF:    cfg.max_half    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_item.price = s_tdata;
  assign s_item.upd   = s_tuser;

  vql_front u_front (
    .clk(clk), .rst(rst), .s_valid(s_tvalid), .s_ready(s_tready), .s_item(s_item),
    .push(push), .push_item(push_item), .full(full)
  );

  vql_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .full(full),
    .pop(q_pop), .valid(q_valid), .item(q_item)
  );

  vql_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop), .m_valid(m_tvalid), .m_ready(m_tready), .m_quote(quote)
  );

  assign m_tdata = {5'd0, quote.depth, quote.price, quote.level};
  assign m_tuser = quote.side;
  assign m_tlast = quote.last;

endmodule

FILE: src/vql_checker.sv
// Port-level checks on the quote ladder, bound to the top level.
`include "volatility_quote_ladder_top_macros.svh"

module vql_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  `VQL_ASSERT_RST(a_idle_after_reset, rst |=> !m_tvalid)
  `VQL_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid)
  `VQL_ASSERT(a_level_range, m_tvalid |-> (m_tdata[3:0] != 4'd0) && (m_tdata[3:0] <= 4'd8))
  `VQL_ASSERT(a_last_is_ask, m_tvalid && m_tlast |-> m_tuser)

endmodule

bind volatility_quote_ladder_top vql_checker u_vql_checker (.*);

FILE: dv/testbench.sv
// Self-checking testbench for the volatility quote ladder: stream driver, stream monitor, quote predictor.
module testbench import vql_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [24:0] cfg_data = '0;

  volatility_quote_ladder_top dut (.*);

  initial forever #5 clk = ~clk;

  // predictor state
  logic [31:0] hist [WINDOW];
  int unsigned hist_cnt, hist_head;
  logic [3:0]  p_levels;
  logic [19:0] p_depth;
  logic [24:0] p_spread;
  logic [15:0] p_mult;
  logic [24:0] p_maxhalf;

  item_t  price_q [$];
  quote_t quote_q [$];
  int     errors = 0;
  logic   long_hold = 1'b0;
  int     hold_left = 0;

  function automatic longint ret_at(int unsigned k);
    int unsigned oldest;
    logic [31:0] pv, cv;
    longint diff;
    longint unsigned mag;
    oldest = (hist_head + WINDOW - hist_cnt) % WINDOW;
    pv = hist[(oldest + k - 1) % WINDOW];
    cv = hist[(oldest + k) % WINDOW];
    if (pv == 0) return 0;
    diff = longint'({32'd0, cv}) - longint'({32'd0, pv});
    mag = (diff < 0 ? -diff : diff);
    mag = (mag << 24) / pv;
    if (mag > (64'd1 << 27)) mag = 64'd1 << 27;
    return diff < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned window_vol();
    int unsigned n;
    longint s, mean, d;
    longint unsigned sq, mq;
    if (hist_cnt < 2) return 0;
    n = hist_cnt - 1;
    s = 0;
    for (int unsigned k = 1; k <= n; k++) s += ret_at(k);
    mq = (s < 0 ? -s : s) / n;
    mean = s < 0 ? -longint'(mq) : longint'(mq);
    sq = 0;
    for (int unsigned k = 1; k <= n; k++) begin
      d = ret_at(k) - mean;
      mq = d < 0 ? -d : d;
      sq += mq * mq;
    end
    return int_sqrt(sq / n);
  endfunction

  task automatic predict_quotes(item_t it);
    longint unsigned half, offs, dep, px, q;
    int unsigned lv;
    quote_t qt;
    int first;
    if (it.price == 0) return;
    if (it.upd) begin
      hist[hist_head] = it.price;
      hist_head = (hist_head + 1) % WINDOW;
      if (hist_cnt < WINDOW) hist_cnt++;
    end
    half = p_spread + ((window_vol() * p_mult) >> 8);
    if (half > p_maxhalf) half = p_maxhalf;
    lv = p_levels > MAX_LEVELS ? MAX_LEVELS : p_levels;
    px = it.price;
    first = quote_q.size();
    for (int unsigned i = 1; i <= lv; i++) begin
      offs = half * i;
      dep = p_depth * i;
      if (dep > DEPTH_MAX) dep = DEPTH_MAX;
      qt.level = 4'(i);
      qt.depth = 23'(dep);
      qt.last = 1'b0;
      if (offs < (64'd1 << 24)) begin
        q = (px * ((64'd1 << 24) - offs)) >> 24;
        if (q > 0) begin
          qt.side = 1'b0;
          qt.price = 32'(q);
          quote_q = {quote_q, qt};
        end
      end
      q = (px * ((64'd1 << 24) + offs)) >> 24;
      if (q > 64'hffff_ffff) q = 64'hffff_ffff;
      qt.side = 1'b1;
      qt.price = 32'(q);
      quote_q = {quote_q, qt};
    end
    if (quote_q.size() > first) quote_q[$].last = 1'b1;
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // driver
  int send_gap = 0;
  logic gaps_on = 1'b1;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_quotes(price_q[0]);
        price_q.delete(0);
        send_gap <= gaps_on ? gap_len() : 0;
        if (price_q.size() > 0 && !(gaps_on && gap_len() > 0)) begin
          s_tdata <= price_q[0].price;
          s_tuser <= price_q[0].upd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end else if (!s_tvalid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (price_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= price_q[0].price;
          s_tuser <= price_q[0].upd;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  quote_t got, want;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.side = m_tuser;
        got.level = m_tdata[3:0];
        got.price = m_tdata[35:4];
        got.depth = m_tdata[58:36];
        got.last = m_tlast;
        if (quote_q.size() == 0) begin
          $error("unexpected quote side=%0d level=%0d price=%0d", got.side, got.level, got.price);
          errors++;
        end else begin
          want = quote_q[0];
          quote_q.delete(0);
          if (got.side != want.side) begin
            $error("side: expected %0d actual %0d", want.side, got.side); errors++;
          end
          if (got.level != want.level) begin
            $error("level: expected %0d actual %0d", want.level, got.level); errors++;
          end
          if (got.price != want.price) begin
            $error("quote_price: expected %0d actual %0d", want.price, got.price); errors++;
          end
          if (got.depth != want.depth) begin
            $error("depth: expected %0d actual %0d", want.depth, got.depth); errors++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0d actual %0d", want.last, got.last); errors++;
          end
        end
      end
      if (long_hold || hold_left > 0) begin
        m_tready <= 1'b0;
        if (hold_left > 0) hold_left <= hold_left - 1;
      end else if (recv_gap > 0) begin
        m_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        recv_gap <= gap_len();
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [24:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LEVELS:      p_levels = val[3:0];
      REG_BASE_DEPTH:  p_depth = val[19:0];
      REG_BASE_SPREAD: p_spread = val;
      REG_VOL_MULT:    p_mult = val[15:0];
      REG_MAX_HALF:    p_maxhalf = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_price(logic [31:0] p, logic u);
    item_t it;
    it.price = p;
    it.upd = u;
    price_q = {price_q, it};
  endtask

  task automatic drain();
    while (price_q.size() > 0 || s_tvalid || quote_q.size() > 0) @(posedge clk);
    // zero-level items may still be in flight, each up to a full window of work
    repeat (20000) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_price();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(1, 20);
      2: return 32'hffff_ffff - $urandom_range(0, 3);
      default: return 32'd1_000_000 + $urandom_range(0, 40000) - 20000;
    endcase
  endfunction

  initial begin
    logic [31:0] base;
    hist_cnt = 0;
    hist_head = 0;
    p_levels = 4'd3;
    p_depth = 20'd100;
    p_spread = 25'd16777;
    p_mult = 16'd256;
    p_maxhalf = 25'd838861;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, zero price, single price, extremes
    queue_price(32'd0, 1'b1);
    queue_price(32'd1_000_000, 1'b0);
    queue_price(32'd1_000_000, 1'b1);
    queue_price(32'd1_050_000, 1'b1);
    queue_price(32'd0, 1'b0);
    queue_price(32'hffff_ffff, 1'b1);
    queue_price(32'd1, 1'b1);
    queue_price(32'd3, 1'b0);
    queue_price(32'h8000_0000, 1'b1);
    queue_price(32'h5555_5555, 1'b1);
    queue_price(32'haaaa_aaaa, 1'b0);
    drain();
    // levels over the max, huge depth, full-scale spread, no cap
    write_reg(REG_LEVELS, 25'd15);
    write_reg(REG_BASE_DEPTH, 25'hfffff);
    write_reg(REG_BASE_SPREAD, 25'h100_0000);
    write_reg(REG_VOL_MULT, 25'hffff);
    write_reg(REG_MAX_HALF, 25'h1ff_ffff);
    queue_price(32'd1000, 1'b1);
    queue_price(32'hffff_ffff, 1'b0);
    drain();
    write_reg(REG_BASE_SPREAD, 25'd0);
    write_reg(REG_VOL_MULT, 25'd0);
    write_reg(REG_MAX_HALF, 25'd0);
    write_reg(REG_BASE_DEPTH, 25'd0);
    queue_price(32'd7, 1'b1);
    queue_price(32'd9, 1'b0);
    drain();
    write_reg(REG_LEVELS, 25'd0);
    queue_price(32'd5000, 1'b1);
    queue_price(32'd5001, 1'b1);
    drain();

    // random phases, each with new settings; one phase without any gaps
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_LEVELS, 25'($urandom_range(1, 9)));
      write_reg(REG_BASE_DEPTH, 25'($urandom_range(0, 20'hfffff)));
      write_reg(REG_BASE_SPREAD, (ph % 3 == 0) ? 25'($urandom_range(0, 25'h100_0000))
                                               : 25'($urandom_range(0, 200000)));
      write_reg(REG_VOL_MULT, 25'($urandom_range(0, 16'hffff)));
      write_reg(REG_MAX_HALF, (ph == 7) ? 25'h100_0000
                                        : 25'($urandom_range(0, 25'h1ff_ffff)));
      gaps_on = (ph != 4);
      base = rand_price() | 32'd1;
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          base = base + $urandom_range(0, 2000) - 1000;
          if (base == 0) base = 1;
          queue_price(base, $urandom_range(0, 4) != 0);
        end else begin
          queue_price(($urandom_range(0, 3) == 0) ? 32'd0 : rand_price(),
                      1'($urandom_range(0, 1)));
        end
      end
      if (ph == 2) begin
        // receiver holds off while the sender keeps offering
        long_hold = 1'b1;
        repeat (20000) @(posedge clk);
        long_hold = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("volatility_quote_ladder_top regression: pass");
    end else begin
      $display("volatility_quote_ladder_top regression: fail");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("volatility_quote_ladder_top regression: fail");
    $finish;
  end
endmodule
